// ----- sv/kts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kts_pkg: shared types and constants of the keyframe track sampler
// Holds the sequencer state type, opcode, config and track codes, and the divider request and reply types.
// ----------------------------------------------------------------------------
package kts_pkg;

	localparam int unsigned TRACKS = 3;
	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [1:0] CFG_POSITION = 2'd0;
	localparam logic [1:0] CFG_ROTATION = 2'd1;
	localparam logic [1:0] CFG_SCALING  = 2'd2;

	localparam logic [1:0] TRK_POSITION = 2'd0;
	localparam logic [1:0] TRK_ROTATION = 2'd1;
	localparam logic [1:0] TRK_SCALING  = 2'd2;
	localparam logic [1:0] TRK_UNUSED   = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TRACK,
		ST_RD_FIRST,
		ST_RD_LAST,
		ST_SEARCH,
		ST_SEARCH_WAIT,
		ST_RD_LO,
		ST_RD_HI,
		ST_DIVIDE,
		ST_LERP_MUL,
		ST_LERP_ADD,
		ST_EMIT
	} seq_state_t;

	// Request to the divider and its reply.
	typedef struct packed {
		logic        start;
		logic [47:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [16:0] factor;
	} div_rsp_t;

endpackage
`default_nettype wire

// ----- sv/keyframe_track_sampler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_track_sampler: keyframe tracks with binary search and lerp
// Three time-sorted key tracks in one memory, sampled by linear interpolation.
// ----------------------------------------------------------------------------
// Usage. A request is taken when start is high and busy is low. With opcode
// write, the key (key_time, key_x/y/z) goes to slot key_slot of the chosen
// track at the accepting edge and busy stays low; a track code of three or a
// slot past the table is dropped. With opcode sample, every track with a
// nonzero key count is sampled at sample_time and yields one result on
// out_track/out_x/y/z with valid high for one cycle; last marks the final
// result of the request. Key counts are written through cfg_we/cfg_index/
// cfg_data while idle; a count above KEYS_PER_TRACK is used as KEYS_PER_TRACK.
// Sequence. Per nonempty track: pick the track, read the first and last key,
// run the binary search (six steps for 64 keys) and close it, read the
// bracketing pair, divide in the serial divider, multiply and add, and
// present the result. A time clamped to either end skips the search and
// the divider. The work is serial over the single memory read port and the
// divider; a new request waits for busy. Reset clears counts and the
// sequencer; key memory is not cleared, so a never-written key reads as
// anything. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module keyframe_track_sampler #(
	parameter int unsigned KEYS_PER_TRACK = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic                opcode,
	input  wire logic [1:0]          track,
	input  wire logic [5:0]          key_slot,
	input  wire logic [31:0]         key_time,
	input  wire logic signed [31:0]  key_x,
	input  wire logic signed [31:0]  key_y,
	input  wire logic signed [31:0]  key_z,
	input  wire logic [31:0]         sample_time,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [6:0]          cfg_data,
	output logic                     valid,
	output logic [1:0]               out_track,
	output logic signed [31:0]       out_x,
	output logic signed [31:0]       out_y,
	output logic signed [31:0]       out_z,
	output logic                     last
);

	localparam int unsigned DEPTH = 3 * KEYS_PER_TRACK;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned NW    = $clog2(KEYS_PER_TRACK + 1);

	kts_pkg::seq_state_t state_q, state_d;

	logic [6:0]  cnt_q [3];
	logic [31:0] t_q;
	logic [1:0]  trk_q;
	logic [NW-1:0] n_q, lo_q, hi_q, mid_q;
	logic [31:0] tlo_q;
	logic [95:0] vlo_q, vhi_q, res_q;
	logic [16:0] f_q;
	logic signed [50:0] prod_x_q, prod_y_q, prod_z_q;
	logic signed [32:0] dx, dy, dz;
	logic [AW-1:0] rd_addr;
	logic [127:0]  rd_data;
	logic [31:0]   rd_t;
	logic [95:0]   rd_val;
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	kts_pkg::div_req_t dreq;
	kts_pkg::div_rsp_t drsp;
	logic        more;
	logic [NW-1:0] n_next;
	logic [NW-1:0] mid;

	// Clamped count of a track.
	function automatic logic [NW-1:0] clamp_n(input logic [6:0] c);
		logic [NW-1:0] r;
		if ({25'd0, c} > 32'(KEYS_PER_TRACK)) begin
			r = NW'(KEYS_PER_TRACK);
		end else begin
			r = NW'(c);
		end
		return r;
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [1:0] t, input logic [NW-1:0] s);
		return AW'(AW'(t) * AW'(KEYS_PER_TRACK) + AW'(s));
	endfunction

	assign mid = NW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

	assign wr_en   = start && !busy && opcode == kts_pkg::OP_WRITE
		&& track != kts_pkg::TRK_UNUSED && {26'd0, key_slot} < 32'(KEYS_PER_TRACK);
	assign wr_addr = AW'(AW'(track) * AW'(KEYS_PER_TRACK) + AW'(key_slot));

	kts_key_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data ({key_time, key_x, key_y, key_z}),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	kts_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
			cnt_q[2] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				kts_pkg::CFG_POSITION: cnt_q[0] <= cfg_data;
				kts_pkg::CFG_ROTATION: cnt_q[1] <= cfg_data;
				kts_pkg::CFG_SCALING:  cnt_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A later nonempty track exists after trk_q, so this result is not the last.
	always_comb begin
		more = 1'b0;
		if (trk_q == kts_pkg::TRK_POSITION && (cnt_q[1] != 7'd0 || cnt_q[2] != 7'd0))
			more = 1'b1;
		if (trk_q == kts_pkg::TRK_ROTATION && cnt_q[2] != 7'd0)
			more = 1'b1;
	end

	// Clamped count of the track after trk_q.
	always_comb begin
		case (trk_q)
			kts_pkg::TRK_POSITION: n_next = clamp_n(cnt_q[1]);
			kts_pkg::TRK_ROTATION: n_next = clamp_n(cnt_q[2]);
			default: n_next = '0;
		endcase
	end

	assign rd_t   = rd_data[127:96];
	assign rd_val = rd_data[95:0];

	// Next state, memory read address, divider request and result strobe.
	always_comb begin
		state_d = state_q;
		rd_addr = addr_of(trk_q, '0);
		valid   = 1'b0;
		dreq.start = 1'b0;
		dreq.num   = {16'd0, t_q - tlo_q} << 16;
		dreq.den   = rd_t - tlo_q;
		case (state_q)
			kts_pkg::ST_IDLE: begin
				if (start && opcode == kts_pkg::OP_SAMPLE)
					state_d = kts_pkg::ST_TRACK;
			end
			kts_pkg::ST_TRACK: begin
				if (n_q == '0) begin
					state_d = (trk_q == kts_pkg::TRK_SCALING) ? kts_pkg::ST_IDLE
						: kts_pkg::ST_TRACK;
				end else begin
					rd_addr = addr_of(trk_q, '0);
					state_d = kts_pkg::ST_RD_FIRST;
				end
			end
			kts_pkg::ST_RD_FIRST: begin
				// A single key or a time at or before the first key.
				if (n_q == NW'(1) || t_q <= rd_t) begin
					state_d = kts_pkg::ST_EMIT;
				end else begin
					rd_addr = addr_of(trk_q, n_q - NW'(1));
					state_d = kts_pkg::ST_RD_LAST;
				end
			end
			kts_pkg::ST_RD_LAST: begin
				// A time at or after the last key in use.
				state_d = (t_q >= rd_t) ? kts_pkg::ST_EMIT : kts_pkg::ST_SEARCH;
			end
			kts_pkg::ST_SEARCH: begin
				if (hi_q - lo_q > NW'(1)) begin
					rd_addr = addr_of(trk_q, mid);
					state_d = kts_pkg::ST_SEARCH_WAIT;
				end else begin
					rd_addr = addr_of(trk_q, lo_q);
					state_d = kts_pkg::ST_RD_LO;
				end
			end
			kts_pkg::ST_SEARCH_WAIT: state_d = kts_pkg::ST_SEARCH;
			kts_pkg::ST_RD_LO: begin
				if (hi_q >= n_q) begin
					state_d = kts_pkg::ST_EMIT;
				end else begin
					rd_addr = addr_of(trk_q, hi_q);
					state_d = kts_pkg::ST_RD_HI;
				end
			end
			kts_pkg::ST_RD_HI: begin
				// Equal or descending key times, or a time not past the start
				// key, give the start key's value.
				if (rd_t <= tlo_q || t_q <= tlo_q) begin
					state_d = kts_pkg::ST_EMIT;
				end else begin
					dreq.start = 1'b1;
					state_d = kts_pkg::ST_DIVIDE;
				end
			end
			kts_pkg::ST_DIVIDE: if (drsp.done) state_d = kts_pkg::ST_LERP_MUL;
			kts_pkg::ST_LERP_MUL: state_d = kts_pkg::ST_LERP_ADD;
			kts_pkg::ST_LERP_ADD: state_d = kts_pkg::ST_EMIT;
			kts_pkg::ST_EMIT: begin
				valid = 1'b1;
				state_d = more ? kts_pkg::ST_TRACK : kts_pkg::ST_IDLE;
			end
			default: state_d = kts_pkg::ST_IDLE;
		endcase
	end

	assign busy = state_q != kts_pkg::ST_IDLE;

	assign dx = $signed({vhi_q[95], vhi_q[95:64]}) - $signed({vlo_q[95], vlo_q[95:64]});
	assign dy = $signed({vhi_q[63], vhi_q[63:32]}) - $signed({vlo_q[63], vlo_q[63:32]});
	assign dz = $signed({vhi_q[31], vhi_q[31:0]}) - $signed({vlo_q[31], vlo_q[31:0]});

	// Datapath registers, loaded in the state that produces each value.
	always_ff @(posedge clk) begin
		case (state_q)
			kts_pkg::ST_IDLE: begin
				t_q   <= sample_time;
				trk_q <= kts_pkg::TRK_POSITION;
				n_q   <= clamp_n(cnt_q[0]);
			end
			kts_pkg::ST_TRACK: begin
				lo_q <= '0;
				hi_q <= n_q;
				if (n_q == '0 && trk_q != kts_pkg::TRK_SCALING) begin
					trk_q <= trk_q + 2'd1;
					n_q   <= n_next;
				end
			end
			kts_pkg::ST_RD_FIRST: res_q <= rd_val;
			kts_pkg::ST_RD_LAST:  res_q <= rd_val;
			kts_pkg::ST_SEARCH:   mid_q <= mid;
			kts_pkg::ST_SEARCH_WAIT: begin
				if (rd_t > t_q) begin
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_q;
				end
			end
			kts_pkg::ST_RD_LO: begin
				tlo_q <= rd_t;
				vlo_q <= rd_val;
				res_q <= rd_val;
			end
			kts_pkg::ST_RD_HI: vhi_q <= rd_val;
			kts_pkg::ST_DIVIDE: if (drsp.done) f_q <= drsp.factor;
			kts_pkg::ST_LERP_MUL: begin
				prod_x_q <= $signed({1'b0, f_q}) * dx;
				prod_y_q <= $signed({1'b0, f_q}) * dy;
				prod_z_q <= $signed({1'b0, f_q}) * dz;
			end
			kts_pkg::ST_LERP_ADD: begin
				// Bits 47:16 are the floor of the product over 65536.
				res_q[95:64] <= vlo_q[95:64] + prod_x_q[47:16];
				res_q[63:32] <= vlo_q[63:32] + prod_y_q[47:16];
				res_q[31:0]  <= vlo_q[31:0] + prod_z_q[47:16];
			end
			kts_pkg::ST_EMIT: begin
				if (more) begin
					trk_q <= trk_q + 2'd1;
					n_q   <= n_next;
				end
			end
			default: ;
		endcase
	end

	assign out_track = trk_q;
	assign out_x     = res_q[95:64];
	assign out_y     = res_q[63:32];
	assign out_z     = res_q[31:0];
	assign last      = valid && !more;

`ifndef SYNTH
	a_last_with_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> valid);
	a_valid_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> busy);
	a_track_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> out_track != kts_pkg::TRK_UNUSED);
	a_div_done_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> state_q == kts_pkg::ST_DIVIDE);
`endif

endmodule
`default_nettype wire

// ----- sv/kts_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kts_div: restoring divider for the interpolation factor
// One quotient bit per cycle; the factor saturates to 1.0.
// ----------------------------------------------------------------------------
module kts_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire kts_pkg::div_req_t req,
	output kts_pkg::div_rsp_t     rsp
);

	logic [47:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] rem_sh;
	logic [33:0] diff;

	assign rem_sh = {rem_q[31:0], quo_q[47]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd47;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.factor = (quo_q > {16'd0, kts_pkg::ONE_Q16}) ? kts_pkg::ONE_Q16[16:0]
		: quo_q[16:0];

endmodule
`default_nettype wire

// ----- sv/kts_key_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kts_key_mem: key storage of all tracks
// One synchronous memory of time and value, one write and one read port.
// ----------------------------------------------------------------------------
module kts_key_mem #(
	parameter int unsigned DEPTH = 192,
	parameter int unsigned AW    = 8
) (
	input  wire logic           clk,
	input  wire logic           wr_en,
	input  wire logic [AW-1:0]  wr_addr,
	input  wire logic [127:0]   wr_data,
	input  wire logic [AW-1:0]  rd_addr,
	output logic [127:0]        rd_data
);

	logic [127:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire
